// File: rtl/gtph_pkg.sv
package gtph_pkg;

	localparam int unsigned TEXT_LEN = 38;
	localparam int unsigned ID_BYTES = 16;

	localparam logic [7:0] CH_OPEN  = 8'h7B;
	localparam logic [7:0] CH_CLOSE = 8'h7D;
	localparam logic [7:0] CH_DASH  = 8'h2D;

	// FNV prime 0x100000001b3 = 2^40 + 0x1b3
	localparam int unsigned FNV_SHIFT = 40;
	localparam logic [8:0]  FNV_LOW   = 9'h1B3;

	typedef logic [63:0] word_t;

	// {is_hex, value}
	typedef logic [4:0] hex_t;

	function automatic hex_t hex_decode(logic [7:0] c);
		hex_t r;
		r = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

endpackage

// File: rtl/gtph_if.sv
interface gtph_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       last;

	modport source (output valid, ch, last, input ready);
	modport sink (input valid, ch, last, output ready);
endinterface

interface gtph_out_if;
	logic        valid;
	logic        ready;
	logic        ok;
	logic [63:0] id_first_half;
	logic [63:0] id_second_half;
	logic [63:0] id_hash;

	modport source (output valid, ok, id_first_half, id_second_half, id_hash, input ready);
	modport sink (input valid, ok, id_first_half, id_second_half, id_hash, output ready);
endinterface

// File: rtl/guid_text_parse_hash.sv
// Streaming parser for the braced text form of a 16-byte identifier.
// chars (sink): one ASCII character per item, last marks the end of the
//   string. A string must be 38 characters: '{', 16 bytes as hex digit
//   pairs with optional dashes at byte starts, then '}'.
// result (source): one item per string, issued for the character with
//   last set: ok, the 16 bytes in two 64-bit halves and their FNV-1a 64
//   hash (basis zero). All three words read zero when ok is low.
// Throughput: one character per cycle, unless one with last must wait. Each is
//   decoded as taken; a byte's second digit advances the hash by one constant multiply.
// Latency: the result item is valid in the cycle after the last character
//   is accepted, held in a single output register.
// Stall: while the result waits, characters without last are still taken;
//   a character with last waits until the output register is free or is
//   being drained in the same cycle.
// Reset: arst_n clears all parse state and drops result valid; the next
//   character is taken as position zero of a new string.
module guid_text_parse_hash
	import gtph_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	gtph_in_if.sink           chars,
	gtph_out_if.source        result
);

	localparam logic [5:0] POS_CLOSE = 6'(TEXT_LEN - 1);
	localparam logic [5:0] COUNT_MAX = 6'(TEXT_LEN + 1);
	localparam logic [4:0] BYTES_ALL = 5'(ID_BYTES);

	logic [5:0]   char_count_q;
	logic         second_digit_due_q;
	logic [3:0]   high_digit_q;
	logic [4:0]   bytes_done_q;
	word_t        hash_acc_q;
	logic         failed_q;
	logic [127:0] id_q;

	logic       res_valid_q;
	logic       res_ok_q;
	word_t      res_first_q;
	word_t      res_second_q;
	word_t      res_hash_q;

	logic       accept;
	logic       bytes_full;
	hex_t       hx;
	logic [7:0] byte_val;
	word_t      hash_step;

	logic       failed_d;
	logic       second_digit_due_d;
	logic [3:0] high_digit_d;
	logic [4:0] bytes_done_d;
	word_t      hash_acc_d;
	logic       shift_en;
	logic [5:0] char_count_d;
	logic       ok_d;

	assign chars.ready = !res_valid_q || result.ready || !chars.last;
	assign accept      = chars.valid && chars.ready;

	assign bytes_full = (bytes_done_q == BYTES_ALL);
	assign hx         = hex_decode(chars.ch);
	assign byte_val   = {high_digit_q, hx[3:0]};

	gtph_fnv_step u_fnv (
		.acc      (hash_acc_q),
		.data     (byte_val),
		.acc_next (hash_step)
	);

	always_comb begin
		failed_d           = failed_q;
		second_digit_due_d = second_digit_due_q;
		high_digit_d       = high_digit_q;
		bytes_done_d       = bytes_done_q;
		hash_acc_d         = hash_acc_q;
		shift_en           = 1'b0;
		if (!failed_q) begin
			if (char_count_q == 6'd0) begin
				if (chars.ch != CH_OPEN) begin
					failed_d = 1'b1;
				end
			end else if (char_count_q < POS_CLOSE) begin
				if (!bytes_full) begin
					if (!second_digit_due_q) begin
						if (chars.ch != CH_DASH) begin
							if (!hx[4]) begin
								failed_d = 1'b1;
							end else begin
								high_digit_d       = hx[3:0];
								second_digit_due_d = 1'b1;
							end
						end
					end else if (!hx[4]) begin
						failed_d = 1'b1;
					end else begin
						shift_en           = 1'b1;
						hash_acc_d         = hash_step;
						bytes_done_d       = bytes_done_q + 5'd1;
						second_digit_due_d = 1'b0;
						high_digit_d       = 4'd0;
					end
				end
			end else if (char_count_q == POS_CLOSE) begin
				if (chars.ch != CH_CLOSE || !bytes_full) begin
					failed_d = 1'b1;
				end
			end else begin
				failed_d = 1'b1;
			end
		end
		char_count_d = (char_count_q < COUNT_MAX) ? char_count_q + 6'd1 : char_count_q;
	end

	assign ok_d = !failed_q && (char_count_q == POS_CLOSE) && (chars.ch == CH_CLOSE) &&
		bytes_full;

	// parse state, cleared after every string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_count_q       <= '0;
			second_digit_due_q <= 1'b0;
			high_digit_q       <= '0;
			bytes_done_q       <= '0;
			hash_acc_q         <= '0;
			failed_q           <= 1'b0;
		end else if (accept) begin
			if (chars.last) begin
				char_count_q       <= '0;
				second_digit_due_q <= 1'b0;
				high_digit_q       <= '0;
				bytes_done_q       <= '0;
				hash_acc_q         <= '0;
				failed_q           <= 1'b0;
			end else begin
				char_count_q       <= char_count_d;
				second_digit_due_q <= second_digit_due_d;
				high_digit_q       <= high_digit_d;
				bytes_done_q       <= bytes_done_d;
				hash_acc_q         <= hash_acc_d;
				failed_q           <= failed_d;
			end
		end
	end

	// collected bytes, oldest on top
	always_ff @(posedge clk) begin
		if (accept && shift_en) begin
			id_q <= {id_q[119:0], byte_val};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept && chars.last) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && chars.last) begin
			res_ok_q     <= ok_d;
			res_first_q  <= ok_d ? id_q[127:64] : '0;
			res_second_q <= ok_d ? id_q[63:0] : '0;
			res_hash_q   <= ok_d ? hash_acc_q : '0;
		end
	end

	assign result.valid          = res_valid_q;
	assign result.ok             = res_ok_q;
	assign result.id_first_half  = res_first_q;
	assign result.id_second_half = res_second_q;
	assign result.id_hash        = res_hash_q;

endmodule

// File: rtl/gtph_fnv_step.sv
module gtph_fnv_step
	import gtph_pkg::*;
(
	input  word_t      acc,
	input  logic [7:0] data,
	output word_t      acc_next
);

	word_t       x;
	logic [72:0] low_prod;

	assign x        = acc ^ {56'd0, data};
	assign low_prod = {9'd0, x} * {64'd0, FNV_LOW};
	assign acc_next = (x << FNV_SHIFT) + low_prod[63:0];

endmodule

// File: rtl/gtph_check.sv
module gtph_check (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_last,
	input logic        res_valid,
	input logic        res_ready,
	input logic        res_ok,
	input logic [63:0] res_first,
	input logic [63:0] res_second,
	input logic [63:0] res_hash
);

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_ok) && $stable(res_hash))
		else $error("result item dropped or changed while stalled");

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_last |=> res_valid)
		else $error("no result item after last character");

	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(in_acc && in_last))
		else $error("result item without last character");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ok |-> res_first == 64'd0 && res_second == 64'd0 &&
			res_hash == 64'd0)
		else $error("failed parse carries nonzero fields");

	a_last_waits: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_last && res_valid && !res_ready |-> !in_ready)
		else $error("last character taken while result register full");

endmodule

bind guid_text_parse_hash gtph_check u_gtph_check (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (chars.valid),
	.in_ready   (chars.ready),
	.in_last    (chars.last),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_ok     (result.ok),
	.res_first  (result.id_first_half),
	.res_second (result.id_second_half),
	.res_hash   (result.id_hash)
);

// File: test/guid_text_parse_hash_tb.sv
module guid_text_parse_hash_tb;
	import gtph_pkg::*;

	localparam word_t FNV_PRIME    = 64'h0000_0100_0000_01B3;
	localparam int    RANDOM_CHARS = 800;
	localparam int    LONG_HOLD    = 400;
	localparam int    STALL_LIMIT  = 4000;
	localparam int    ERROR_PRINTS = 50;

	typedef struct packed {
		logic  ok;
		word_t first;
		word_t second;
		word_t hash;
	} id_result_t;

	typedef enum {LC_LOWER, LC_UPPER, LC_MIXED} letter_case_t;
	typedef enum {STR_GOOD, STR_BROKEN, STR_NOISE} str_kind_t;
	typedef enum {
		DEF_SWAP, DEF_DROP, DEF_ADD, DEF_OPEN, DEF_CLOSE, DEF_DASH, DEF_HIGH_BIT,
		DEF_EXTRA_DASHES
	} defect_t;
	typedef enum {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_t;

	logic clk;
	logic arst_n;

	gtph_in_if  chars_if ();
	gtph_out_if result_if ();

	guid_text_parse_hash dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if),
		.result (result_if)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// parser image
	logic [5:0] pos_count;
	logic       low_due;
	logic [3:0] hi_nib;
	logic [4:0] nbytes;
	logic [7:0] id_mem [16];
	word_t      fnv;
	logic       dead;

	id_result_t expected_ids [$];
	logic [7:0] text_q [$];

	int errors       = 0;
	int strings_done = 0;
	int ok_count     = 0;
	int chars_sent   = 0;
	int stall_cycles = 0;
	int hold_asked   = 0;
	int hold_served  = 0;
	int burst_left   = 0;
	bit tx_idle      = 1'b1;

	function automatic logic digit_value(input logic [7:0] c, output logic [3:0] v);
		v = 4'd0;
		if (c inside {[8'h30:8'h39]}) begin
			v = c[3:0];
			return 1'b1;
		end
		if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
			v = c[3:0] + 4'd9;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic clear_parse();
		pos_count = '0;
		low_due   = 1'b0;
		hi_nib    = '0;
		nbytes    = '0;
		fnv       = '0;
		dead      = 1'b0;
	endtask

	task automatic predict_char(input logic [7:0] c, input logic fin);
		logic [3:0] v;
		logic       is_hex;
		logic [7:0] b;
		logic [5:0] at;
		id_result_t r;
		at = pos_count;
		is_hex = digit_value(c, v);
		if (!dead) begin
			if (at == 0) begin
				dead = (c != CH_OPEN);
			end else if (at < TEXT_LEN - 1) begin
				if (nbytes < ID_BYTES) begin
					if (!low_due) begin
						if (c != CH_DASH) begin
							if (!is_hex) begin
								dead = 1'b1;
							end else begin
								hi_nib  = v;
								low_due = 1'b1;
							end
						end
					end else if (!is_hex) begin
						dead = 1'b1;
					end else begin
						b = {hi_nib, v};
						id_mem[nbytes[3:0]] = b;
						fnv = (fnv ^ word_t'(b)) * FNV_PRIME;
						nbytes++;
						low_due = 1'b0;
						hi_nib  = '0;
					end
				end
			end else if (at == TEXT_LEN - 1) begin
				if (c != CH_CLOSE || nbytes < ID_BYTES) dead = 1'b1;
			end else begin
				dead = 1'b1;
			end
		end
		if (pos_count < TEXT_LEN + 1) pos_count++;
		if (fin) begin
			r = '0;
			r.ok = !dead && at == TEXT_LEN - 1 && nbytes == ID_BYTES;
			if (r.ok) begin
				for (int i = 0; i < 8; i++) begin
					r.first  = {r.first[55:0], id_mem[i]};
					r.second = {r.second[55:0], id_mem[i + 8]};
				end
				r.hash = fnv;
			end
			expected_ids.push_back(r);
			strings_done++;
			ok_count += r.ok;
			clear_parse();
		end
	endtask

	task automatic check_field(input string name, input word_t want, input word_t got);
		if (got !== want) begin
			errors++;
			if (errors <= ERROR_PRINTS) $error("%s: expected %h, got %h", name, want, got);
		end
	endtask

	task automatic check_result();
		id_result_t want;
		if (expected_ids.size() == 0) begin
			errors++;
			if (errors <= ERROR_PRINTS)
				$error("result item with nothing expected: ok %b", result_if.ok);
		end else begin
			want = expected_ids.pop_front();
			check_field("ok", word_t'(want.ok), word_t'(result_if.ok));
			check_field("id_first_half", want.first, result_if.id_first_half);
			check_field("id_second_half", want.second, result_if.id_second_half);
			check_field("id_hash", want.hash, result_if.id_hash);
		end
	endtask

	initial clear_parse();

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_if.valid && result_if.ready) check_result();
			if (chars_if.valid && chars_if.ready) predict_char(chars_if.ch, chars_if.last);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (chars_if.valid && chars_if.ready) ||
				(result_if.valid && result_if.ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// result receiver: shifting stall patterns, long hold on request
	initial begin
		rx_mode_t mode;
		int       left;
		int       period;
		int       low_len;
		int       phase;
		logic     rdy;
		result_if.ready = 1'b0;
		mode = RX_OPEN;
		left = 0;
		period = 2;
		low_len = 1;
		phase = 0;
		forever begin
			@(posedge clk);
			if (hold_served != hold_asked) begin
				result_if.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_served++;
			end else begin
				if (left == 0) begin
					mode    = rx_mode_t'($urandom_range(0, 3));
					left    = $urandom_range(32, 256);
					period  = $urandom_range(2, 9);
					low_len = $urandom_range(1, period - 1);
					phase   = 0;
				end
				left--;
				case (mode)
					RX_OPEN: rdy = 1'b1;
					RX_COIN: rdy = 1'($urandom_range(0, 1));
					RX_PERIODIC: begin
						rdy   = (phase >= low_len);
						phase = (phase + 1) % period;
					end
					default: rdy = ($urandom_range(0, 7) != 0);
				endcase
				result_if.ready <= rdy;
			end
		end
	end

	task automatic send_char(input logic [7:0] c, input logic fin);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if (tx_idle) begin
				chars_if.valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
		burst_left--;
		chars_if.ch    <= c;
		chars_if.last  <= fin;
		chars_if.valid <= 1'b1;
		do @(posedge clk); while (!chars_if.ready);
		chars_sent++;
	endtask

	task automatic send_text();
		foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1);
	endtask

	task automatic wait_drained();
		chars_if.valid <= 1'b0;
		do @(posedge clk); while (expected_ids.size() != 0);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] v, input letter_case_t letters);
		logic up;
		up = (letters == LC_UPPER) || (letters == LC_MIXED && $urandom_range(0, 1) == 1);
		if (v < 10) return 8'h30 + v;
		return (up ? 8'h41 : 8'h61) + v - 8'd10;
	endfunction

	function automatic logic [127:0] rand_id();
		return {$urandom, $urandom, $urandom, $urandom};
	endfunction

	// braced text: dashes at byte starts, random filler after the digits
	task automatic build_id(input logic [127:0] id_val, input int dashes, input bit std_dash,
			input letter_case_t letters);
		int         dash_before [16];
		logic [7:0] b;
		text_q.delete();
		foreach (dash_before[i]) dash_before[i] = 0;
		if (std_dash) begin
			dash_before[4]  = 1;
			dash_before[6]  = 1;
			dash_before[8]  = 1;
			dash_before[10] = 1;
		end else begin
			repeat (dashes) dash_before[$urandom_range(0, 15)]++;
		end
		for (int i = 0; i < 16; i++) begin
			b = id_val[127 - 8 * i -: 8];
			repeat (dash_before[i]) text_q.push_back(CH_DASH);
			text_q.push_back(hex_char(b[7:4], letters));
			text_q.push_back(hex_char(b[3:0], letters));
		end
		while (text_q.size() < TEXT_LEN - 2) text_q.push_back(8'($urandom));
		while (text_q.size() > TEXT_LEN - 2) text_q.pop_back();
		text_q.push_front(CH_OPEN);
		text_q.push_back(CH_CLOSE);
	endtask

	task automatic apply_defect(input defect_t d);
		int idx;
		idx = $urandom_range(1, TEXT_LEN - 2);
		case (d)
			DEF_SWAP: text_q[idx] = 8'($urandom);
			DEF_DROP: text_q.delete(idx);
			DEF_ADD: text_q.insert(idx, 8'($urandom));
			DEF_OPEN: text_q[0] = text_q[0] ^ 8'($urandom_range(1, 255));
			DEF_CLOSE: text_q[TEXT_LEN - 1] = text_q[TEXT_LEN - 1] ^ 8'($urandom_range(1, 255));
			DEF_DASH: text_q[idx] = CH_DASH;
			DEF_HIGH_BIT: text_q[idx] = text_q[idx] | 8'h80;
			default: ;
		endcase
	endtask

	task automatic test_well_formed();
		build_id('0, 0, 1'b1, LC_LOWER);
		send_text();
		build_id('1, 0, 1'b1, LC_UPPER);
		send_text();
		build_id(rand_id(), 0, 1'b0, LC_MIXED);
		send_text();
		build_id(rand_id(), 4, 1'b0, LC_MIXED);
		send_text();
		build_id(128'h0123456789ABCDEF_FEDCBA9876543210, 2, 1'b0, LC_LOWER);
		send_text();
	endtask

	task automatic test_framing();
		text_q = {CH_OPEN};
		send_text();
		text_q = {8'h00};
		send_text();
		build_id(rand_id(), 0, 1'b1, LC_MIXED);
		text_q.pop_back();
		send_text();
		build_id(rand_id(), 0, 1'b1, LC_MIXED);
		text_q.push_back(CH_CLOSE);
		send_text();
		build_id(rand_id(), 0, 1'b1, LC_UPPER);
		text_q[0] = 8'h5B;
		send_text();
		build_id(rand_id(), 0, 1'b1, LC_LOWER);
		text_q[TEXT_LEN - 1] = 8'h5D;
		send_text();
		build_id(rand_id(), 0, 1'b1, LC_LOWER);
		text_q[0] = CH_CLOSE;
		text_q[TEXT_LEN - 1] = CH_OPEN;
		send_text();
	endtask

	task automatic test_bad_digits();
		build_id(rand_id(), 0, 1'b1, LC_LOWER);
		text_q[2] = CH_DASH;
		send_text();
		build_id(rand_id(), 0, 1'b1, LC_LOWER);
		text_q[1] = 8'h67;
		send_text();
		build_id(rand_id(), 0, 1'b1, LC_UPPER);
		text_q[5] = 8'hB5;
		send_text();
		build_id(rand_id(), 6, 1'b0, LC_MIXED);
		send_text();
	endtask

	task automatic test_ignored_tail();
		build_id(rand_id(), 0, 1'b0, LC_MIXED);
		text_q[33] = CH_CLOSE;
		text_q[34] = CH_DASH;
		text_q[35] = 8'hFF;
		text_q[36] = 8'h67;
		send_text();
	endtask

	// a position counter that wraps would see the brace at 101 as position 37
	task automatic test_length_wrap();
		build_id(rand_id(), 0, 1'b1, LC_MIXED);
		text_q.pop_back();
		while (text_q.size() < 101) text_q.push_back(8'($urandom));
		text_q.push_back(CH_CLOSE);
		send_text();
	endtask

	task automatic test_output_hold();
		tx_idle = 1'b0;
		hold_asked++;
		build_id(rand_id(), 0, 1'b1, LC_MIXED);
		send_text();
		repeat (8) begin
			text_q = {8'($urandom)};
			send_text();
		end
		build_id(rand_id(), 0, 1'b1, LC_MIXED);
		send_text();
		chars_if.valid <= 1'b0;
		do @(posedge clk); while (hold_served != hold_asked);
		tx_idle = 1'b1;
	endtask

	task automatic test_drain_pause();
		repeat (2) begin
			repeat (3) begin
				build_id(rand_id(), $urandom_range(0, 4), 1'($urandom_range(0, 1)), LC_MIXED);
				send_text();
			end
			wait_drained();
		end
	endtask

	task automatic test_random_mix();
		int        base;
		int        pick;
		str_kind_t kind;
		defect_t   d;
		base = chars_sent;
		while (chars_sent - base < RANDOM_CHARS) begin
			if ($urandom_range(0, 7) == 0) tx_idle = !tx_idle;
			pick = $urandom_range(0, 9);
			kind = (pick < 7) ? STR_GOOD : (pick < 9) ? STR_BROKEN : STR_NOISE;
			case (kind)
				STR_GOOD: begin
					build_id(rand_id(), $urandom_range(0, 4), 1'($urandom_range(0, 1)),
						letter_case_t'($urandom_range(0, 2)));
				end
				STR_BROKEN: begin
					d = defect_t'($urandom_range(0, 7));
					if (d == DEF_EXTRA_DASHES) begin
						build_id(rand_id(), $urandom_range(5, 8), 1'b0, LC_MIXED);
					end else begin
						build_id(rand_id(), $urandom_range(0, 4), 1'($urandom_range(0, 1)),
							LC_MIXED);
						apply_defect(d);
					end
				end
				default: begin
					text_q.delete();
					repeat ($urandom_range(1, 45)) text_q.push_back(8'($urandom));
					if ($urandom_range(0, 1) == 1) text_q[0] = CH_OPEN;
				end
			endcase
			send_text();
		end
		tx_idle = 1'b1;
	endtask

	initial begin
		arst_n         = 1'b0;
		chars_if.valid = 1'b0;
		chars_if.ch    = '0;
		chars_if.last  = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_well_formed();
		test_framing();
		test_bad_digits();
		test_ignored_tail();
		test_length_wrap();
		test_output_hold();
		test_drain_pause();
		test_random_mix();
		wait_drained();
		repeat (8) @(posedge clk);
		$display("Parsed %0d strings from %0d characters: %0d valid ids, %0d rejected.",
			strings_done, chars_sent, ok_count, strings_done - ok_count);
		$display("Framing, digit, tail and wrap cases ran, with a long output hold and drains.");
		if (errors == 0 && expected_ids.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/gtph_pkg.sv
rtl/gtph_if.sv
rtl/gtph_fnv_step.sv
rtl/guid_text_parse_hash.sv
rtl/gtph_check.sv
test/guid_text_parse_hash_tb.sv
